>>> sv/rsps_pkg.sv
// Shared types and constants for the range-sum / point-update store.
// Used by the channel interfaces, the engine and the top level.
`timescale 1ns / 1ps

package rsps_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 10;
  localparam int AMOUNT_W    = 16;
  localparam int ELEM_W      = 32;
  localparam int ANSWER_W    = 42;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAKE = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SUM  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 bad;
    logic [IDX_W-1:0]     first;
    logic [IDX_W-1:0]     last;
    logic [AMOUNT_W-1:0]  amount;
  } rsps_cmd_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } rsps_stat_t;

  typedef struct packed {
    logic [ANSWER_W-1:0] answer;
    logic                bad;
  } rsps_res_t;

endpackage

>>> sv/rsps_if.sv
// Request and result channel interfaces (valid/ready words).
// Depends on rsps_pkg for field widths.
`timescale 1ns / 1ps

interface rsps_in_if;
  import rsps_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    first_index;
  logic [IDX_W-1:0]    last_index;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, kind, first_index, last_index, amount, input ready);
  modport sink   (input valid, kind, first_index, last_index, amount, output ready);
endinterface

interface rsps_out_if;
  import rsps_pkg::*;
  logic                valid;
  logic                ready;
  logic [ANSWER_W-1:0] answer;
  logic                bad_request;

  modport source (output valid, answer, bad_request, input ready);
  modport sink   (input valid, answer, bad_request, output ready);
endinterface

>>> sv/rsps_engine.sv
// Element memory, Fenwick tree memory and the walk sequencer.
// Depends on rsps_pkg.
`timescale 1ns / 1ps

module rsps_engine #(
  parameter int ENTRIES = rsps_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  rsps_pkg::rsps_cmd_t  cmd,
  output rsps_pkg::rsps_stat_t stat,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rsps_pkg::rsps_res_t  res
);
  import rsps_pkg::*;

  localparam int A_W = $clog2(ENTRIES);
  localparam int J_W = A_W + 2;
  localparam int T_W = ELEM_W + A_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ELEM, S_UPD_RD, S_UPD_WR, S_SUM_RD, S_SUM_ACC, S_RESULT
  } state_t;

  state_t              state_r;
  logic [A_W-1:0]      clr_addr_r;
  logic [J_W-1:0]      j_r;
  logic [T_W-1:0]      delta_r;
  logic [T_W-1:0]      acc_r;
  logic                lo_phase_r;
  logic                op_add_r;
  logic [IDX_W-1:0]    first_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic                res_valid_r;
  logic [ANSWER_W-1:0] res_answer_r;
  logic                res_bad_r;

  logic [ELEM_W-1:0] elem_mem [ENTRIES];
  logic [T_W-1:0]    tree_mem [ENTRIES];
  logic [ELEM_W-1:0] elem_rdata_r;
  logic [T_W-1:0]    tree_rdata_r;

  logic              elem_we, elem_re, tree_we, tree_re;
  logic [A_W-1:0]    elem_waddr, elem_raddr, tree_waddr, tree_raddr;
  logic [ELEM_W-1:0] elem_wdata;
  logic [T_W-1:0]    tree_wdata;

  logic [J_W-1:0]    j_m1;
  logic [J_W-1:0]    lowbit;
  logic [ELEM_W:0]   sat_sum;
  logic [ELEM_W-1:0] new_val;
  logic              j_past_end;

  assign j_m1       = j_r - 1'b1;
  assign lowbit     = j_r & (~j_r + 1'b1);
  assign j_past_end = j_r > J_W'(ENTRIES);
  assign sat_sum    = {1'b0, elem_rdata_r} + (ELEM_W + 1)'(amount_r);
  assign new_val    = !op_add_r  ? '0 :
                      sat_sum[ELEM_W] ? '1 : sat_sum[ELEM_W-1:0];

  always_comb begin
    elem_we    = 1'b0;
    elem_re    = 1'b0;
    tree_we    = 1'b0;
    tree_re    = 1'b0;
    elem_waddr = A_W'(first_r);
    elem_raddr = A_W'(cmd.first);
    elem_wdata = new_val;
    tree_waddr = j_m1[A_W-1:0];
    tree_raddr = j_m1[A_W-1:0];
    tree_wdata = tree_rdata_r + delta_r;
    unique case (state_r)
      S_CLEAR: begin
        elem_we    = 1'b1;
        tree_we    = 1'b1;
        elem_waddr = clr_addr_r;
        tree_waddr = clr_addr_r;
        elem_wdata = '0;
        tree_wdata = '0;
      end
      S_IDLE:    elem_re = cmd_valid && !cmd.bad && (cmd.kind != KIND_SUM);
      S_ELEM:    elem_we = 1'b1;
      S_UPD_RD:  tree_re = !j_past_end;
      S_UPD_WR:  tree_we = 1'b1;
      S_SUM_RD:  tree_re = (j_r != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    if (elem_re) elem_rdata_r <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    if (tree_re) tree_rdata_r <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == A_W'(ENTRIES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            first_r  <= cmd.first;
            amount_r <= cmd.amount;
            op_add_r <= (cmd.kind == KIND_ADD);
            priority if (cmd.bad) begin
              res_answer_r <= '0;
              res_bad_r    <= 1'b1;
              res_valid_r  <= 1'b1;
              state_r      <= S_RESULT;
            end else if (cmd.kind == KIND_SUM) begin
              j_r        <= J_W'(cmd.last) + 1'b1;
              acc_r      <= '0;
              lo_phase_r <= 1'b0;
              state_r    <= S_SUM_RD;
            end else begin
              state_r <= S_ELEM;
            end
          end
        end
        S_ELEM: begin
          delta_r      <= T_W'(new_val) - T_W'(elem_rdata_r);
          res_answer_r <= ANSWER_W'(elem_rdata_r);
          res_bad_r    <= 1'b0;
          j_r          <= J_W'(first_r) + 1'b1;
          state_r      <= S_UPD_RD;
        end
        S_UPD_RD: begin
          if (j_past_end) begin
            if (op_add_r) begin
              state_r <= S_IDLE;
            end else begin
              res_valid_r <= 1'b1;
              state_r     <= S_RESULT;
            end
          end else begin
            state_r <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          j_r     <= j_r + lowbit;
          state_r <= S_UPD_RD;
        end
        S_SUM_RD: begin
          if (j_r == '0) begin
            if (lo_phase_r) begin
              res_answer_r <= ANSWER_W'(acc_r);
              res_bad_r    <= 1'b0;
              res_valid_r  <= 1'b1;
              state_r      <= S_RESULT;
            end else begin
              lo_phase_r <= 1'b1;
              j_r        <= J_W'(first_r);
            end
          end else begin
            state_r <= S_SUM_ACC;
          end
        end
        S_SUM_ACC: begin
          acc_r   <= lo_phase_r ? acc_r - tree_rdata_r : acc_r + tree_rdata_r;
          j_r     <= j_r - lowbit;
          state_r <= S_SUM_RD;
        end
        S_RESULT: begin
          if (res_ready) begin
            res_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign stat.idle     = (state_r == S_IDLE);
  assign stat.clearing = (state_r == S_CLEAR);
  assign res_valid     = res_valid_r;
  assign res.answer    = res_answer_r;
  assign res.bad       = res_bad_r;

endmodule

>>> sv/range_sum_point_update_store.sv
// Range-sum store with point update: request checking, output word register.
// Depends on rsps_pkg, rsps_if and rsps_engine.
//
// Request channel in_ch: kind (0 take and clear, 1 add, 2 range sum),
// first_index, last_index, amount. Result channel out_ch: answer and
// bad_request. An add that succeeds produces no result word; every other
// request produces exactly one.
// After reset both memories are cleared, one entry per cycle: in_ch.ready
// stays low until the clear is done.
// One request is worked at a time. A rejected request goes straight to the
// result word. Take or add reads the element, writes it back and then runs
// the Fenwick update walk, one read and one write of the tree memory per
// step. A range sum runs two prefix walks, each step a read state and an
// accumulate state.
// The result sits in an output register; the engine takes the next request
// while it waits, and stalls only when it has a second result to hand over.
`timescale 1ns / 1ps

module range_sum_point_update_store #(
  parameter int ENTRIES = rsps_pkg::ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rsps_in_if.sink    in_ch,
  rsps_out_if.source out_ch
);
  import rsps_pkg::*;

  rsps_cmd_t  cmd;
  rsps_stat_t eng_stat;
  rsps_res_t  eng_res;
  logic       cmd_valid;
  logic       eng_res_valid;
  logic       eng_res_ready;
  logic       first_oor;
  logic       last_oor;

  logic                out_valid_r;
  logic [ANSWER_W-1:0] out_answer_r;
  logic                out_bad_r;

  assign first_oor = 32'(in_ch.first_index) >= 32'(ENTRIES);
  assign last_oor  = 32'(in_ch.last_index) >= 32'(ENTRIES);

  always_comb begin
    cmd.kind   = kind_t'(in_ch.kind);
    cmd.first  = in_ch.first_index;
    cmd.last   = in_ch.last_index;
    cmd.amount = in_ch.amount;
    unique case (in_ch.kind)
      KIND_TAKE, KIND_ADD: cmd.bad = first_oor;
      KIND_SUM: cmd.bad = first_oor || last_oor ||
                          (in_ch.first_index > in_ch.last_index);
      default: cmd.bad = 1'b1;
    endcase
  end

  assign in_ch.ready = eng_stat.idle;
  assign cmd_valid   = in_ch.valid && in_ch.ready;

  rsps_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (eng_stat),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  assign eng_res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      out_valid_r  <= 1'b1;
      out_answer_r <= eng_res.answer;
      out_bad_r    <= eng_res.bad;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.answer      = out_answer_r;
  assign out_ch.bad_request = out_bad_r;

`ifndef ASSERT_OFF
  a_bad_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd.bad) |=> (eng_res_valid && eng_res.bad))
    else $error("rejected request did not produce an error word");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_res_valid && eng_res.bad) |-> (eng_res.answer == '0))
    else $error("error word carries a nonzero answer");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (eng_stat.clearing && !in_ch.ready))
    else $error("store not clearing right after reset");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res_valid |-> !in_ch.ready)
    else $error("request taken while a result is pending in the engine");
`endif

endmodule

>>> dv/range_sum_point_update_store_test.sv
// Testbench for range_sum_point_update_store: directed and random take, add and
// range-sum words checked against an in-bench copy of the element store.
// Depends on rsps_pkg, rsps_if and the store RTL.
`timescale 1ns / 1ps

module range_sum_point_update_store_test;
  import rsps_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_WORDS = 900;
  localparam int DRAIN_AT = 450;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    first;
    logic [IDX_W-1:0]    last;
    logic [AMOUNT_W-1:0] amount;
    logic                drain_first;
  } request_t;

  typedef struct {
    logic                produced;
    logic [ANSWER_W-1:0] answer;
    logic                bad;
  } reply_t;

  logic clk;
  logic rst_n;

  rsps_in_if  in_ch ();
  rsps_out_if out_ch ();

  range_sum_point_update_store #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t          pending_requests[$];
  reply_t            expected_replies[$];
  logic [ELEM_W-1:0] element_copy[NUM_ENTRIES];
  int                mismatch_count;
  int                cycle_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic reply_t apply_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] f,
                                           logic [IDX_W-1:0] l, logic [AMOUNT_W-1:0] amt);
    reply_t              rep;
    logic [ELEM_W:0]     total;
    logic [ANSWER_W-1:0] acc;
    rep.produced = 1'b1;
    rep.answer   = '0;
    rep.bad      = 1'b1;
    case (k)
      KIND_TAKE: begin
        if (int'(f) < NUM_ENTRIES) begin
          rep.answer      = ANSWER_W'(element_copy[f]);
          rep.bad         = 1'b0;
          element_copy[f] = '0;
        end
      end
      KIND_ADD: begin
        if (int'(f) < NUM_ENTRIES) begin
          total           = {1'b0, element_copy[f]} + (ELEM_W + 1)'(amt);
          element_copy[f] = total[ELEM_W] ? '1 : total[ELEM_W-1:0];
          rep.produced    = 1'b0;
          rep.bad         = 1'b0;
        end
      end
      KIND_SUM: begin
        if (int'(f) < NUM_ENTRIES && int'(l) < NUM_ENTRIES && f <= l) begin
          acc = '0;
          for (int i = int'(f); i <= int'(l); i++) acc += ANSWER_W'(element_copy[i]);
          rep.answer = acc;
          rep.bad    = 1'b0;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return IDX_W'($urandom_range(0, 15));
    if (r < 50) return '0;
    if (r < 55) return IDX_W'(NUM_ENTRIES - 1);
    return IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
  endfunction

  function automatic request_t random_request();
    request_t          req;
    int                r;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    req.first       = IDX_W'($urandom);
    req.last        = IDX_W'($urandom);
    req.amount      = AMOUNT_W'($urandom);
    req.drain_first = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      req.kind  = KIND_ADD;
      req.first = pick_index();
      r = $urandom_range(0, 99);
      if (r < 15) req.amount = '1;
      else if (r < 30) req.amount = AMOUNT_W'($urandom_range(0, 15));
    end else if (r < 60) begin
      req.kind  = KIND_TAKE;
      req.first = pick_index();
    end else if (r < 95) begin
      req.kind = KIND_SUM;
      a = pick_index();
      b = pick_index();
      r = $urandom_range(0, 99);
      if (r < 5) begin
        a = '0;
        b = IDX_W'(NUM_ENTRIES - 1);
      end else if (r < 90 && a > b) begin
        req.first = b;
        b = a;
        a = req.first;
      end
      req.first = a;
      req.last  = b;
    end else begin
      req.kind = KIND_UNUSED;
    end
    return req;
  endfunction

  task automatic queue_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] f,
                               logic [IDX_W-1:0] l, logic [AMOUNT_W-1:0] amt,
                               logic drain);
    request_t req;
    req.kind        = k;
    req.first       = f;
    req.last        = l;
    req.amount      = amt;
    req.drain_first = drain;
    pending_requests.push_back(req);
  endtask

  // driver: predicts on accept, then offers the next word
  int       send_gap;
  int       send_calm;
  request_t send_req;
  reply_t   send_rep;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        send_rep = apply_request(in_ch.kind, in_ch.first_index, in_ch.last_index,
                                 in_ch.amount);
        if (send_rep.produced) expected_replies.push_back(send_rep);
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          send_calm = 40;
          send_gap  = 0;
        end else begin
          send_gap = next_gap();
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || pending_requests.size() == 0 ||
            (pending_requests[0].drain_first && expected_replies.size() != 0)) begin
          in_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          send_req = pending_requests.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.kind        <= send_req.kind;
          in_ch.first_index <= send_req.first;
          in_ch.last_index  <= send_req.last;
          in_ch.amount      <= send_req.amount;
        end
      end
    end
  end

  // monitor: checks result words, drives ready with random stalls
  int     recv_stall;
  int     recv_calm;
  int     words_seen;
  logic   long_hold_done;
  reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall     = 0;
      recv_calm      = 0;
      words_seen     = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected word: answer %0d bad_request %0b",
                 out_ch.answer, out_ch.bad_request);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.answer !== want.answer) begin
            $error("answer: expected %0d, got %0d", want.answer, out_ch.answer);
            mismatch_count++;
          end
          if (out_ch.bad_request !== want.bad) begin
            $error("bad_request: expected %0b, got %0b", want.bad, out_ch.bad_request);
            mismatch_count++;
          end
        end
        words_seen++;
        if (words_seen == LONG_HOLD_AT && !long_hold_done) begin
          long_hold_done = 1'b1;
          recv_stall     = LONG_HOLD_CYCLES;
        end
      end
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else if (recv_calm > 0) begin
        out_ch.ready <= 1'b1;
        recv_calm--;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ch.ready <= 1'b1;
        recv_calm = 60;
      end else begin
        recv_stall = next_gap();
        if (recv_stall == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          recv_stall--;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("range_sum_point_update_store test failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = '0;
    in_ch.first_index = '0;
    in_ch.last_index  = '0;
    in_ch.amount      = '0;
    out_ch.ready      = 1'b0;
    mismatch_count    = 0;
    cycle_count       = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) element_copy[i] = '0;

    // directed: empty store, extremes, reversed ranges, unused kind
    queue_request(KIND_TAKE,   0,    1023, 16'hFFFF, 1'b0);
    queue_request(KIND_SUM,    0,    1023, 16'h0000, 1'b0);
    queue_request(KIND_ADD,    0,    0,    16'hFFFF, 1'b0);
    queue_request(KIND_ADD,    0,    1023, 16'hFFFF, 1'b0);
    queue_request(KIND_ADD,    1023, 0,    16'h0001, 1'b0);
    queue_request(KIND_ADD,    1023, 1023, 16'hFFFF, 1'b0);
    queue_request(KIND_ADD,    512,  0,    16'h0000, 1'b0);
    queue_request(KIND_ADD,    341,  682,  16'h5555, 1'b0);
    queue_request(KIND_ADD,    682,  341,  16'hAAAA, 1'b0);
    queue_request(KIND_SUM,    0,    0,    16'hFFFF, 1'b0);
    queue_request(KIND_SUM,    1023, 1023, 16'h0000, 1'b0);
    queue_request(KIND_SUM,    0,    1023, 16'h0000, 1'b0);
    queue_request(KIND_SUM,    1,    1022, 16'h0000, 1'b0);
    queue_request(KIND_SUM,    1023, 0,    16'h0000, 1'b0);
    queue_request(KIND_SUM,    6,    5,    16'h0000, 1'b0);
    queue_request(KIND_UNUSED, 0,    0,    16'h0000, 1'b0);
    queue_request(KIND_UNUSED, 1023, 1023, 16'hFFFF, 1'b0);
    queue_request(KIND_TAKE,   0,    0,    16'h0000, 1'b0);
    queue_request(KIND_TAKE,   0,    0,    16'h0000, 1'b0);
    queue_request(KIND_TAKE,   1023, 1023, 16'hFFFF, 1'b0);
    queue_request(KIND_SUM,    0,    1023, 16'h0000, 1'b0);
    queue_request(KIND_TAKE,   341,  0,    16'h0000, 1'b1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pending_requests.push_back(random_request());
      if (n == DRAIN_AT) pending_requests[$].drain_first = 1'b1;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_ch.valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("range_sum_point_update_store test passed");
    end else begin
      $display("range_sum_point_update_store test failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rsps_pkg.sv
sv/rsps_if.sv
sv/rsps_engine.sv
sv/range_sum_point_update_store.sv
dv/range_sum_point_update_store_test.sv
